// ----- design/bdlr_pkg.sv -----
package bdlr_pkg;

   localparam int BUTTONS  = 8;
   localparam int IDX_W    = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
   localparam int PIN_W    = 8;
   localparam int TIME_W   = 32;
   localparam int CFG_W    = 16;
   localparam int KIND_W   = 2;
   localparam int BIDX_W   = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LONG     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT   = CSR_IDX_W'(2);

   localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(50);
   localparam logic [CFG_W-1:0] LONG_RST     = CFG_W'(1000);
   localparam logic [CFG_W-1:0] REPEAT_RST   = CFG_W'(200);

   localparam logic [KIND_W-1:0] EV_NONE   = KIND_W'(0);
   localparam logic [KIND_W-1:0] EV_SHORT  = KIND_W'(1);
   localparam logic [KIND_W-1:0] EV_LONG   = KIND_W'(2);
   localparam logic [KIND_W-1:0] EV_REPEAT = KIND_W'(3);

   typedef struct packed {
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] since;
      logic [CFG_W-1:0]  limit;
   } cmp_req_type;

endpackage

// ----- design/bdlr_elapsed_cmp.sv -----
module bdlr_elapsed_cmp (
   input  bdlr_pkg::cmp_req_type cmp_req,
   output logic                  over
);

   logic [bdlr_pkg::TIME_W-1:0] delta;

   assign delta = cmp_req.now - cmp_req.since;
   assign over  = delta > {{(bdlr_pkg::TIME_W-bdlr_pkg::CFG_W){1'b0}}, cmp_req.limit};

endmodule

// ----- design/button_debounce_long_press_repeat_unit.sv -----
// Button debounce with long press and auto-repeat. Each poll on req carries a
// 32-bit millisecond timestamp (bits 31:0) and eight active-low raw button
// levels (bits 39:32); every poll gives exactly one result on rsp: the event
// kind on rsp_tuser (0 none, 1 short, 2 long, 3 repeat) and the button index
// on rsp_tdata. Buttons are visited in index order, each in a debounce state
// and then a hold state, through one shared wrap-around elapsed-time subtract
// and compare: the debounce state checks the debounce timer, the hold state
// checks the hold or repeat timer. The scan stops at the first event; the
// finish state loads the result onto rsp, waiting while an earlier one is held
// there, and the next poll is taken back in the idle state; req_tready is low
// meanwhile. A finished result may wait on rsp while the next poll is taken.
// Registers 0 to 2 (debounce, long press and repeat times in ms, 16 bits) are
// written through csr; csr_ready is low while a scan is running.
module button_debounce_long_press_repeat_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // now_ms[31:0], pin_levels[39:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // button_index[2:0], zero[7:3]
   output logic [bdlr_pkg::KIND_W-1:0]    rsp_tuser,   // event_kind[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bdlr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bdlr_pkg::CFG_W-1:0]     csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_DEBOUNCE, ST_HOLD, ST_FINISH} state_type;

   state_type                       state_ff;
   logic [bdlr_pkg::IDX_W-1:0]      idx_ff;
   logic [bdlr_pkg::TIME_W-1:0]     now_ff;
   logic [bdlr_pkg::PIN_W-1:0]      pins_ff;
   logic [bdlr_pkg::KIND_W-1:0]     kind_ff;
   logic                            rsp_valid_ff;
   logic [bdlr_pkg::KIND_W-1:0]     rsp_kind_ff;
   logic [bdlr_pkg::BIDX_W-1:0]     rsp_index_ff;
   logic [bdlr_pkg::CFG_W-1:0]      debounce_ff;
   logic [bdlr_pkg::CFG_W-1:0]      long_ff;
   logic [bdlr_pkg::CFG_W-1:0]      repeat_ff;

   logic                            raw_prev_ff    [bdlr_pkg::BUTTONS];
   logic                            stable_ff      [bdlr_pkg::BUTTONS];
   logic                            long_seen_ff   [bdlr_pkg::BUTTONS];
   logic [bdlr_pkg::TIME_W-1:0]     change_time_ff [bdlr_pkg::BUTTONS];
   logic [bdlr_pkg::TIME_W-1:0]     press_time_ff  [bdlr_pkg::BUTTONS];
   logic [bdlr_pkg::TIME_W-1:0]     repeat_time_ff [bdlr_pkg::BUTTONS];

   logic [bdlr_pkg::BUTTONS-1:0]    lvl_vec;
   logic                            level;
   logic [bdlr_pkg::TIME_W-1:0]     change_in;
   bdlr_pkg::cmp_req_type           cmp_req;
   logic                            over;
   logic                            accept_lvl;
   logic                            short_ev;
   logic                            hold_active;
   logic                            long_ev;
   logic                            rep_ev;
   logic                            last_btn;
   logic                            load_rsp;
   logic [bdlr_pkg::IDX_W+bdlr_pkg::BIDX_W-1:0] idx_ext;

   for (genvar b = 0; b < bdlr_pkg::BUTTONS; b++) begin : g_lvl
      if (b < bdlr_pkg::PIN_W) begin : g_pin
         assign lvl_vec[b] = pins_ff[b];
      end else begin : g_none
         assign lvl_vec[b] = 1'b1;
      end
   end

   assign level     = lvl_vec[idx_ff];
   assign change_in = (level != raw_prev_ff[idx_ff]) ? now_ff : change_time_ff[idx_ff];
   assign last_btn  = idx_ff == bdlr_pkg::IDX_W'(bdlr_pkg::BUTTONS - 1);
   assign idx_ext   = {{bdlr_pkg::BIDX_W{1'b0}}, idx_ff};
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      cmp_req.now = now_ff;
      if (state_ff == ST_DEBOUNCE) begin
         cmp_req.since = change_in;
         cmp_req.limit = debounce_ff;
      end else if (long_seen_ff[idx_ff]) begin
         cmp_req.since = repeat_time_ff[idx_ff];
         cmp_req.limit = repeat_ff;
      end else begin
         cmp_req.since = press_time_ff[idx_ff];
         cmp_req.limit = long_ff;
      end
   end

   bdlr_elapsed_cmp u_cmp (
      .cmp_req (cmp_req),
      .over    (over)
   );

   assign accept_lvl  = (state_ff == ST_DEBOUNCE) && over && (level != stable_ff[idx_ff]);
   assign short_ev    = accept_lvl && level && !long_seen_ff[idx_ff];
   assign hold_active = (state_ff == ST_HOLD) && !stable_ff[idx_ff];
   assign long_ev     = hold_active && !long_seen_ff[idx_ff] && over;
   assign rep_ev      = hold_active && long_seen_ff[idx_ff] && over;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < bdlr_pkg::BUTTONS; b++) begin
            raw_prev_ff[b]    <= 1'b1;
            stable_ff[b]      <= 1'b1;
            long_seen_ff[b]   <= 1'b0;
            change_time_ff[b] <= '0;
            press_time_ff[b]  <= '0;
            repeat_time_ff[b] <= '0;
         end
      end else begin
         if (state_ff == ST_DEBOUNCE) begin
            raw_prev_ff[idx_ff]    <= level;
            change_time_ff[idx_ff] <= change_in;
         end
         if (accept_lvl) begin
            stable_ff[idx_ff] <= level;
            if (!level) begin
               press_time_ff[idx_ff] <= now_ff;
               long_seen_ff[idx_ff]  <= 1'b0;
            end
         end
         if (long_ev) begin
            long_seen_ff[idx_ff]   <= 1'b1;
            repeat_time_ff[idx_ff] <= now_ff;
         end
         if (rep_ev) begin
            repeat_time_ff[idx_ff] <= now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         kind_ff      <= bdlr_pkg::EV_NONE;
         rsp_valid_ff <= 1'b0;
         debounce_ff  <= bdlr_pkg::DEBOUNCE_RST;
         long_ff      <= bdlr_pkg::LONG_RST;
         repeat_ff    <= bdlr_pkg::REPEAT_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bdlr_pkg::REG_DEBOUNCE: debounce_ff <= csr_data;
               bdlr_pkg::REG_LONG:     long_ff     <= csr_data;
               bdlr_pkg::REG_REPEAT:   repeat_ff   <= csr_data;
               default: ;
            endcase
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  now_ff   <= req_tdata[31:0];
                  pins_ff  <= req_tdata[39:32];
                  idx_ff   <= '0;
                  kind_ff  <= bdlr_pkg::EV_NONE;
                  state_ff <= ST_DEBOUNCE;
               end
            end
            ST_DEBOUNCE: begin
               if (short_ev) begin
                  kind_ff  <= bdlr_pkg::EV_SHORT;
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (long_ev) begin
                  kind_ff  <= bdlr_pkg::EV_LONG;
                  state_ff <= ST_FINISH;
               end else if (rep_ev) begin
                  kind_ff  <= bdlr_pkg::EV_REPEAT;
                  state_ff <= ST_FINISH;
               end else if (last_btn) begin
                  state_ff <= ST_FINISH;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_DEBOUNCE;
               end
            end
            ST_FINISH: begin
               if (load_rsp) begin
                  rsp_kind_ff  <= kind_ff;
                  rsp_index_ff <= (kind_ff == bdlr_pkg::EV_NONE) ? '0 :
                                  idx_ext[bdlr_pkg::BIDX_W-1:0];
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0_0000, rsp_index_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign csr_ready  = state_ff == ST_IDLE;

`ifndef SYNTH
   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_DEBOUNCE && idx_ff == '0))
      else $error("scan did not start at the first button");

   a_none_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_kind_ff == bdlr_pkg::EV_NONE) |-> (rsp_index_ff == '0))
      else $error("no-event result carries a nonzero button index");

   a_long_marks: assert property (@(posedge clock) disable iff (reset)
      long_ev |=> long_seen_ff[$past(idx_ff)])
      else $error("long event did not mark the button as held");

   a_event_stops: assert property (@(posedge clock) disable iff (reset)
      (short_ev || long_ev || rep_ev) |=> (state_ff == ST_FINISH))
      else $error("scan continued past an event");
`endif

endmodule

// ----- verif/tb_button_debounce_long_press_repeat_unit.sv -----
`timescale 1ns / 100ps

module tb_button_debounce_long_press_repeat_unit;

   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 20;
   localparam int SETTINGS_RUN = 6;
   localparam int POLLS_PER_SETTING = 138;
   localparam int SCRIPT_LEN = 24;
   localparam logic [bdlr_pkg::CSR_IDX_W-1:0] REG_UNUSED = bdlr_pkg::CSR_IDX_W'(3);

   typedef struct packed {
      logic [bdlr_pkg::KIND_W-1:0] kind;
      logic [bdlr_pkg::BIDX_W-1:0] button;
   } button_event_type;

   typedef struct packed {
      logic [bdlr_pkg::TIME_W-1:0] stamp;
      logic [bdlr_pkg::PIN_W-1:0]  pins;
      bit                          typed;
      logic [bdlr_pkg::KIND_W-1:0] kind;
      logic [bdlr_pkg::BIDX_W-1:0] button;
   } poll_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [39:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [7:0]        rsp_tdata;
   logic [bdlr_pkg::KIND_W-1:0]    rsp_tuser;
   logic              csr_valid;
   logic              csr_ready;
   logic [bdlr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bdlr_pkg::CFG_W-1:0]     csr_data;

   // predicted per-button state and timing registers
   logic [bdlr_pkg::BUTTONS-1:0] raw_last;
   logic [bdlr_pkg::BUTTONS-1:0] level_held;
   logic [bdlr_pkg::BUTTONS-1:0] long_flag;
   logic [bdlr_pkg::TIME_W-1:0]  edge_ms  [bdlr_pkg::BUTTONS];
   logic [bdlr_pkg::TIME_W-1:0]  press_ms [bdlr_pkg::BUTTONS];
   logic [bdlr_pkg::TIME_W-1:0]  rep_ms   [bdlr_pkg::BUTTONS];
   logic [bdlr_pkg::CFG_W-1:0]   deb_cfg;
   logic [bdlr_pkg::CFG_W-1:0]   long_cfg;
   logic [bdlr_pkg::CFG_W-1:0]   rep_cfg;

   button_event_type pending_events[$];
   int errors = 0;
   int polls_sent = 0;
   int kind_seen [4] = '{0, 0, 0, 0};
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stall_hold = 0;

   poll_row_type script [0:SCRIPT_LEN-1] = '{
      '{32'd0,          8'hFF, 1'b1, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd10,         8'hFE, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd60,         8'hFE, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd61,         8'hFE, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1061,       8'hFE, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1062,       8'hFE, 1'b1, bdlr_pkg::EV_LONG,   3'd0},
      '{32'd1262,       8'hFE, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1263,       8'hFE, 1'b1, bdlr_pkg::EV_REPEAT, 3'd0},
      '{32'd1300,       8'hFF, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1351,       8'hFF, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1400,       8'h7F, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1451,       8'h7F, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1460,       8'hFF, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1511,       8'hFF, 1'b1, bdlr_pkg::EV_SHORT,  3'd7},
      '{32'd1600,       8'h7E, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1651,       8'h7E, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1700,       8'hFF, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1751,       8'hFF, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'd1752,       8'hFF, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'hFFFF_FFF0,  8'hBF, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'h0000_0030,  8'hBF, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'hFFFF_FFFF,  8'hBF, 1'b1, bdlr_pkg::EV_LONG,   3'd6},
      '{32'hFFFF_FFFF,  8'h00, 1'b0, bdlr_pkg::EV_NONE,   3'd0},
      '{32'h0000_0040,  8'h00, 1'b0, bdlr_pkg::EV_NONE,   3'd0}
   };

   button_debounce_long_press_repeat_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_buttons();
      deb_cfg = bdlr_pkg::DEBOUNCE_RST;
      long_cfg = bdlr_pkg::LONG_RST;
      rep_cfg = bdlr_pkg::REPEAT_RST;
      raw_last = '1;
      level_held = '1;
      long_flag = '0;
      for (int i = 0; i < bdlr_pkg::BUTTONS; i++) begin
         edge_ms[i] = '0;
         press_ms[i] = '0;
         rep_ms[i] = '0;
      end
   endfunction

   function automatic void scan_buttons(input logic [bdlr_pkg::TIME_W-1:0] t,
                                        input logic [bdlr_pkg::PIN_W-1:0] p,
                                        output logic [bdlr_pkg::KIND_W-1:0] k,
                                        output logic [bdlr_pkg::BIDX_W-1:0] b);
      logic lvl;
      k = bdlr_pkg::EV_NONE;
      b = '0;
      for (int i = 0; i < bdlr_pkg::BUTTONS && k == bdlr_pkg::EV_NONE; i++) begin
         lvl = (i < bdlr_pkg::PIN_W) ? p[i] : 1'b1;
         if (lvl != raw_last[i])
            edge_ms[i] = t;
         raw_last[i] = lvl;
         if (t - edge_ms[i] > {16'd0, deb_cfg} && lvl != level_held[i]) begin
            level_held[i] = lvl;
            if (!lvl) begin
               press_ms[i] = t;
               long_flag[i] = 1'b0;
            end else if (!long_flag[i]) begin
               k = bdlr_pkg::EV_SHORT;
               b = bdlr_pkg::BIDX_W'(i);
            end
         end
         if (!level_held[i]) begin
            if (!long_flag[i]) begin
               if (t - press_ms[i] > {16'd0, long_cfg}) begin
                  long_flag[i] = 1'b1;
                  rep_ms[i] = t;
                  k = bdlr_pkg::EV_LONG;
                  b = bdlr_pkg::BIDX_W'(i);
               end
            end else if (t - rep_ms[i] > {16'd0, rep_cfg}) begin
               rep_ms[i] = t;
               k = bdlr_pkg::EV_REPEAT;
               b = bdlr_pkg::BIDX_W'(i);
            end
         end
      end
   endfunction

   // call at a falling edge; returns at a falling edge with req_tvalid still high
   task automatic send_poll(input logic [bdlr_pkg::TIME_W-1:0] t,
                            input logic [bdlr_pkg::PIN_W-1:0] p,
                            input bit typed, input logic [bdlr_pkg::KIND_W-1:0] k_typed,
                            input logic [bdlr_pkg::BIDX_W-1:0] b_typed);
      logic [bdlr_pkg::KIND_W-1:0] k;
      logic [bdlr_pkg::BIDX_W-1:0] b;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {p, t};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      scan_buttons(t, p, k, b);
      if (typed)
         pending_events.push_back('{k_typed, b_typed});
      else
         pending_events.push_back('{k, b});
      polls_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [bdlr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bdlr_pkg::CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         bdlr_pkg::REG_DEBOUNCE: deb_cfg = val;
         bdlr_pkg::REG_LONG:     long_cfg = val;
         bdlr_pkg::REG_REPEAT:   rep_cfg = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_times(input logic [bdlr_pkg::CFG_W-1:0] deb,
                                input logic [bdlr_pkg::CFG_W-1:0] hold,
                                input logic [bdlr_pkg::CFG_W-1:0] rep);
      write_reg(REG_UNUSED, bdlr_pkg::CFG_W'($urandom));
      write_reg(bdlr_pkg::REG_DEBOUNCE, deb);
      write_reg(bdlr_pkg::REG_LONG, hold);
      write_reg(bdlr_pkg::REG_REPEAT, rep);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_results();
      while (pending_events.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (stall_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_hold) @(negedge clock);
            stall_hold = 0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      button_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         kind_seen[rsp_tuser]++;
         if (pending_events.size() == 0) begin
            $display("%0t: result with no poll waiting, got kind %0d button %0d",
                     $time, rsp_tuser, rsp_tdata[2:0]);
            errors++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[2:0] !== want.button) begin
               $display("%0t: event mismatch, expected kind %0d button %0d, got kind %0d button %0d",
                        $time, want.kind, want.button, rsp_tuser, rsp_tdata[2:0]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, pending_events.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [bdlr_pkg::TIME_W-1:0] t_ms;
      logic [bdlr_pkg::PIN_W-1:0]  held;
      logic [bdlr_pkg::PIN_W-1:0]  pins;
      logic [bdlr_pkg::CFG_W-1:0]  deb;
      logic [bdlr_pkg::CFG_W-1:0]  hold;
      logic [bdlr_pkg::CFG_W-1:0]  rep;
      int                          step_max;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle_pct = 38;
      rsp_idle_pct = 57;
      clear_buttons();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < SCRIPT_LEN; r++)
         send_poll(script[r].stamp, script[r].pins, script[r].typed,
                   script[r].kind, script[r].button);
      req_tvalid <= 1'b0;
      drain_results();

      t_ms = 32'd5000;
      held = '0;
      for (int s = 0; s < SETTINGS_RUN; s++) begin
         send_idle_pct = (s < 2) ? 38 : (s < 4) ? 57 : 0;
         rsp_idle_pct = (s < 2) ? 57 : (s < 4) ? 38 : 0;
         case (s)
            0: begin deb = 16'd3;     hold = 16'd25;    rep = 16'd6;     step_max = 4;     end
            1: begin deb = 16'd0;     hold = 16'd0;     rep = 16'd0;     step_max = 3;     end
            2: begin deb = 16'hFFFF;  hold = 16'hFFFF;  rep = 16'hFFFF;  step_max = 40000; end
            3: begin
               deb = 16'd1;
               hold = 16'd10;
               rep = 16'd2;
               step_max = 3;
               t_ms = 32'hFFFF_FF00;
            end
            4: begin
               deb = bdlr_pkg::DEBOUNCE_RST;
               hold = bdlr_pkg::LONG_RST;
               rep = bdlr_pkg::REPEAT_RST;
               step_max = 120;
            end
            default: begin
               deb = bdlr_pkg::CFG_W'($urandom_range(0, 8));
               hold = bdlr_pkg::CFG_W'($urandom_range(0, 40));
               rep = bdlr_pkg::CFG_W'($urandom_range(0, 10));
               step_max = 5;
            end
         endcase
         program_times(deb, hold, rep);
         for (int n = 0; n < POLLS_PER_SETTING; n++) begin
            t_ms = t_ms + bdlr_pkg::TIME_W'($urandom_range(0, step_max));
            if ($urandom_range(0, 99) < 12)
               held = held ^ (bdlr_pkg::PIN_W'(1) << $urandom_range(0, bdlr_pkg::PIN_W - 1));
            pins = ~held;
            if ($urandom_range(0, 99) < 8)
               pins = pins ^ (bdlr_pkg::PIN_W'(1) << $urandom_range(0, bdlr_pkg::PIN_W - 1));
            if ($urandom_range(0, 99) < 3)
               pins = bdlr_pkg::PIN_W'($urandom);
            if (s == SETTINGS_RUN - 1 && n == 20)
               stall_hold = 300;
            send_poll(t_ms, pins, 1'b0, bdlr_pkg::EV_NONE, '0);
         end
         req_tvalid <= 1'b0;
         drain_results();
      end

      $display("Ran %0d polls: a directed script, then %0d timing settings with mixed idling",
               polls_sent, SETTINGS_RUN);
      $display("Events seen: %0d short, %0d long, %0d repeat, %0d with no event",
               kind_seen[bdlr_pkg::EV_SHORT], kind_seen[bdlr_pkg::EV_LONG],
               kind_seen[bdlr_pkg::EV_REPEAT], kind_seen[bdlr_pkg::EV_NONE]);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- button_debounce_long_press_repeat_unit.f -----
design/bdlr_pkg.sv
design/bdlr_elapsed_cmp.sv
design/button_debounce_long_press_repeat_unit.sv
verif/tb_button_debounce_long_press_repeat_unit.sv
